// File: rtl/bpa_pkg.sv
// ---------------------------------------------------------------------------
// Buddy page allocator package
// Sizes, codes and memory entry types shared by the allocator RTL.
// ---------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

   // Pool geometry.
   localparam int MAX_PAGES = 1024;
   localparam int MAX_ORDER = 11;
   localparam int PAGE_W    = 10;
   localparam int ORDER_W   = 4;
   localparam int LINK_W    = 11;
   localparam int COUNT_W   = 11;

   // A link value of MAX_PAGES marks the end of a list.
   localparam logic [LINK_W-1:0] NIL = LINK_W'(MAX_PAGES);

   // Request kinds.
   typedef enum logic [1:0] {
      KIND_ALLOC = 2'd0,
      KIND_FREE  = 2'd1,
      KIND_INIT  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   // Response status codes.
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TOO_LARGE = 2'd1,
      STATUS_NO_MEMORY = 2'd2,
      STATUS_BAD_FREE  = 2'd3
   } status_type;

   // Per-page attributes: block order and allocated flag.
   typedef struct packed {
      logic [ORDER_W-1:0] order;
      logic               alloc;
   } attr_entry_type;

   // Per-page free-list links.
   typedef struct packed {
      logic [LINK_W-1:0] next;
      logic [LINK_W-1:0] prev;
   } link_entry_type;

   // Link memory write port, with separate enables for each half.
   typedef struct packed {
      logic              next_en;
      logic              prev_en;
      logic [PAGE_W-1:0] addr;
      link_entry_type    data;
   } link_wr_type;

endpackage : bpa_pkg

`default_nettype wire

// File: rtl/buddy_page_allocator.sv
// ---------------------------------------------------------------------------
// Buddy page allocator
// Allocates and frees power-of-two page blocks from a pool, keeping per-page
// attributes and free-list links in two single-port-write memories.
// ---------------------------------------------------------------------------
//
//  Channel   Ports                       Handshake
//  --------  --------------------------  ------------------------------------
//  request   req_*, start, busy          taken when start && !busy
//  response  rsp_*, rsp_valid            one-cycle strobe, cannot be held off
//  config    csr_pool_pages, csr_valid   written when csr_valid && csr_ready
//
//  Allocate makes s splits of the found block (s at most 10); an order
//  error or an empty pool answers straight from idle. Free merges the
//  block with its buddy while it can, each merge being a read of the
//  buddy's attributes and links and up to two link writes, plus a buddy
//  check when a buddy is looked up and refused; a bad free answers after
//  at most one attribute read. Initialize runs a one-entry-per-cycle
//  sweep of the attribute memory over the pool.
//  Reset clears the control state and empties every free list; no memory
//  sweep is needed after reset. The response side cannot stall the block.
//
`default_nettype none

module buddy_page_allocator
   import bpa_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // Request channel.
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [1:0]          req_kind,
   input  wire logic [ORDER_W-1:0]  req_request_order,
   input  wire logic [PAGE_W-1:0]   req_page_index,
   // Response channel.
   output logic                     rsp_valid,
   output logic [1:0]               rsp_status,
   output logic [PAGE_W-1:0]        rsp_block_page,
   output logic [ORDER_W-1:0]       rsp_block_order,
   output logic [COUNT_W-1:0]       rsp_free_pages,
   // Configuration channel.
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [COUNT_W-1:0]  csr_pool_pages
);

   typedef enum logic [13:0] {
      ST_IDLE    = 14'b00000000000001,
      ST_A_LINK  = 14'b00000000000010,
      ST_A_SPLIT = 14'b00000000000100,
      ST_A_FIN   = 14'b00000000001000,
      ST_F_CHK   = 14'b00000000010000,
      ST_F_BUD   = 14'b00000000100000,
      ST_F_BCHK  = 14'b00000001000000,
      ST_F_UNL1  = 14'b00000010000000,
      ST_F_UNL2  = 14'b00000100000000,
      ST_F_PUSH  = 14'b00001000000000,
      ST_F_PUSH2 = 14'b00010000000000,
      ST_I_SWEEP = 14'b00100000000000,
      ST_I_HEAD  = 14'b01000000000000,
      ST_RESP    = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [COUNT_W-1:0]  pool_pages_ff;
   logic [COUNT_W-1:0]  pool_size_ff, pool_size_in;
   logic [COUNT_W-1:0]  free_total_ff, free_total_in;
   logic [LINK_W-1:0]   head_ff [MAX_ORDER];

   logic [PAGE_W-1:0]   p_ff, p_in;
   logic [PAGE_W-1:0]   b_ff, b_in;
   logic [ORDER_W-1:0]  k_ff, k_in;
   logic [ORDER_W-1:0]  req_ff, req_in;
   logic [COUNT_W-1:0]  idx_ff, idx_in;
   logic [COUNT_W-1:0]  cur_ff, cur_in;
   logic [LINK_W-1:0]   nx_ff, nx_in;
   logic [LINK_W-1:0]   pr_ff, pr_in;
   logic [1:0]          status_ff, status_in;
   logic [PAGE_W-1:0]   bpage_ff, bpage_in;
   logic [ORDER_W-1:0]  border_ff, border_in;

   // Memories and their ports.
   attr_entry_type      attr_mem [MAX_PAGES];
   link_entry_type      link_mem [MAX_PAGES];
   attr_entry_type      attr_q;
   link_entry_type      link_q;
   logic                attr_we;
   logic [PAGE_W-1:0]   attr_waddr;
   attr_entry_type      attr_wdata;
   logic [PAGE_W-1:0]   attr_raddr;
   link_wr_type         link_wr;
   logic [PAGE_W-1:0]   link_raddr;

   // Free-list head write port.
   logic                head_clr;
   logic                head_we;
   logic [ORDER_W-1:0]  head_widx;
   logic [LINK_W-1:0]   head_wdata;

   // Lowest non-empty list at or above the requested order.
   logic                found;
   logic [ORDER_W-1:0]  k_found;
   logic [ORDER_W-1:0]  head_ridx;
   logic [LINK_W-1:0]   head_rd;
   logic [COUNT_W-1:0]  pow_k;
   logic [COUNT_W-1:0]  pow_req;
   logic [COUNT_W-1:0]  pow_attr;
   logic [PAGE_W-1:0]   buddy;
   logic [COUNT_W-1:0]  buddy_end;
   logic                take;

   assign busy      = (state_ff != ST_IDLE);
   assign take      = start && !busy;
   assign csr_ready = 1'b1;

   // Response outputs come straight from registers.
   assign rsp_valid       = (state_ff == ST_RESP);
   assign rsp_status      = status_ff;
   assign rsp_block_page  = bpage_ff;
   assign rsp_block_order = border_ff;
   assign rsp_free_pages  = free_total_ff;

   // Search the list heads for the lowest usable order.
   always_comb begin
      found   = 1'b0;
      k_found = '0;
      for (int j = MAX_ORDER - 1; j >= 0; j--) begin
         if (head_ff[j] != NIL && ORDER_W'(j) >= req_request_order) begin
            found   = 1'b1;
            k_found = ORDER_W'(j);
         end
      end
   end

   assign head_ridx = (state_ff == ST_IDLE) ? k_found : k_ff;
   assign head_rd   = head_ff[head_ridx];
   assign pow_k     = COUNT_W'(1) << k_ff;
   assign pow_req   = COUNT_W'(1) << req_request_order;
   assign pow_attr  = COUNT_W'(1) << attr_q.order;
   assign buddy     = p_ff ^ pow_k[PAGE_W-1:0];
   assign buddy_end = {1'b0, buddy} + pow_k;

   // Sequencer: next state, memory ports and list head updates.
   always_comb begin
      state_in      = state_ff;
      pool_size_in  = pool_size_ff;
      free_total_in = free_total_ff;
      p_in          = p_ff;
      b_in          = b_ff;
      k_in          = k_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      cur_in        = cur_ff;
      nx_in         = nx_ff;
      pr_in         = pr_ff;
      status_in     = status_ff;
      bpage_in      = bpage_ff;
      border_in     = border_ff;
      attr_we       = 1'b0;
      attr_waddr    = p_ff;
      attr_wdata    = '{order: k_ff, alloc: 1'b0};
      attr_raddr    = p_ff;
      link_wr       = '{next_en: 1'b0, prev_en: 1'b0, addr: p_ff,
                        data: '{next: NIL, prev: NIL}};
      link_raddr    = p_ff;
      head_clr      = 1'b0;
      head_we       = 1'b0;
      head_widx     = k_ff;
      head_wdata    = NIL;

      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               status_in = STATUS_OK;
               bpage_in  = '0;
               border_in = '0;
               state_in  = ST_RESP;
               case (req_kind)
                  KIND_ALLOC: begin
                     if (req_request_order >= ORDER_W'(MAX_ORDER)) begin
                        status_in = STATUS_TOO_LARGE;
                     end else if (!found) begin
                        status_in = STATUS_NO_MEMORY;
                     end else begin
                        p_in          = head_rd[PAGE_W-1:0];
                        k_in          = k_found;
                        req_in        = req_request_order;
                        link_raddr    = head_rd[PAGE_W-1:0];
                        free_total_in = free_total_ff - pow_req;
                        bpage_in      = head_rd[PAGE_W-1:0];
                        border_in     = req_request_order;
                        state_in      = ST_A_LINK;
                     end
                  end
                  KIND_FREE: begin
                     bpage_in = req_page_index;
                     if ({1'b0, req_page_index} >= pool_size_ff) begin
                        status_in = STATUS_BAD_FREE;
                     end else begin
                        p_in       = req_page_index;
                        attr_raddr = req_page_index;
                        state_in   = ST_F_CHK;
                     end
                  end
                  KIND_INIT: begin
                     pool_size_in  = (pool_pages_ff > COUNT_W'(MAX_PAGES)) ?
                                     COUNT_W'(MAX_PAGES) : pool_pages_ff;
                     free_total_in = pool_size_in;
                     head_clr      = 1'b1;
                     idx_in        = '0;
                     state_in      = ST_I_SWEEP;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         // The taken block was a list head: its successor becomes the head.
         ST_A_LINK: begin
            head_we    = 1'b1;
            head_widx  = k_ff;
            head_wdata = link_q.next;
            if (link_q.next != NIL) begin
               link_wr.prev_en   = 1'b1;
               link_wr.addr      = link_q.next[PAGE_W-1:0];
               link_wr.data.prev = NIL;
            end
            state_in = (k_ff == req_ff) ? ST_A_FIN : ST_A_SPLIT;
         end

         // Split once: the upper half becomes the sole block of an empty list.
         ST_A_SPLIT: begin
            attr_we    = 1'b1;
            attr_waddr = p_ff + (pow_k[PAGE_W:1]);
            attr_wdata = '{order: k_ff - 1'b1, alloc: 1'b0};
            link_wr    = '{next_en: 1'b1, prev_en: 1'b1,
                           addr: p_ff + (pow_k[PAGE_W:1]),
                           data: '{next: NIL, prev: NIL}};
            head_we    = 1'b1;
            head_widx  = k_ff - 1'b1;
            head_wdata = {1'b0, p_ff + (pow_k[PAGE_W:1])};
            k_in       = k_ff - 1'b1;
            if (k_ff - 1'b1 == req_ff) begin
               state_in = ST_A_FIN;
            end
         end

         // Mark the kept block (the lower half after any split) as allocated.
         ST_A_FIN: begin
            attr_we    = 1'b1;
            attr_waddr = p_ff;
            attr_wdata = '{order: req_ff, alloc: 1'b1};
            state_in   = ST_RESP;
         end

         // Check that the page heads an allocated block.
         ST_F_CHK: begin
            if (!attr_q.alloc) begin
               status_in = STATUS_BAD_FREE;
               state_in  = ST_RESP;
            end else begin
               border_in     = attr_q.order;
               k_in          = attr_q.order;
               free_total_in = free_total_ff + pow_attr;
               attr_we       = 1'b1;
               attr_waddr    = p_ff;
               attr_wdata    = '{order: attr_q.order, alloc: 1'b0};
               state_in      = ST_F_BUD;
            end
         end

         // Look up the buddy if a merge is still possible.
         ST_F_BUD: begin
            if (k_ff < ORDER_W'(MAX_ORDER - 1) && buddy_end <= pool_size_ff) begin
               b_in       = buddy;
               attr_raddr = buddy;
               state_in   = ST_F_BCHK;
            end else begin
               state_in = ST_F_PUSH;
            end
         end

         // A free buddy of equal order is merged; fetch its links.
         ST_F_BCHK: begin
            if (attr_q.order == k_ff && !attr_q.alloc) begin
               link_raddr = b_ff;
               state_in   = ST_F_UNL1;
            end else begin
               state_in = ST_F_PUSH;
            end
         end

         // Unlink the buddy: predecessor side.
         ST_F_UNL1: begin
            nx_in = link_q.next;
            pr_in = link_q.prev;
            if (link_q.prev != NIL) begin
               link_wr.next_en   = 1'b1;
               link_wr.addr      = link_q.prev[PAGE_W-1:0];
               link_wr.data.next = link_q.next;
            end else begin
               head_we    = 1'b1;
               head_widx  = k_ff;
               head_wdata = link_q.next;
            end
            state_in = ST_F_UNL2;
         end

         // Unlink the buddy: successor side, then step up one order.
         ST_F_UNL2: begin
            if (nx_ff != NIL) begin
               link_wr.prev_en   = 1'b1;
               link_wr.addr      = nx_ff[PAGE_W-1:0];
               link_wr.data.prev = pr_ff;
            end
            p_in     = p_ff & ~pow_k[PAGE_W-1:0];
            k_in     = k_ff + 1'b1;
            state_in = ST_F_BUD;
         end

         // Push the merged block onto the head of its list.
         ST_F_PUSH: begin
            attr_we    = 1'b1;
            attr_waddr = p_ff;
            attr_wdata = '{order: k_ff, alloc: 1'b0};
            link_wr    = '{next_en: 1'b1, prev_en: 1'b1, addr: p_ff,
                           data: '{next: head_rd, prev: NIL}};
            head_we    = 1'b1;
            head_widx  = k_ff;
            head_wdata = {1'b0, p_ff};
            nx_in      = head_rd;
            state_in   = (head_rd != NIL) ? ST_F_PUSH2 : ST_RESP;
         end

         // The old head now points back at the pushed block.
         ST_F_PUSH2: begin
            link_wr.prev_en   = 1'b1;
            link_wr.addr      = nx_ff[PAGE_W-1:0];
            link_wr.data.prev = {1'b0, p_ff};
            state_in          = ST_RESP;
         end

         // Clear the attributes of every pool page.
         ST_I_SWEEP: begin
            if (idx_ff < pool_size_ff) begin
               attr_we    = 1'b1;
               attr_waddr = idx_ff[PAGE_W-1:0];
               attr_wdata = '{order: '0, alloc: 1'b0};
               idx_in     = idx_ff + 1'b1;
            end else begin
               k_in     = ORDER_W'(MAX_ORDER - 1);
               cur_in   = '0;
               state_in = ST_I_HEAD;
            end
         end

         // One aligned block per set bit of the pool size, largest first.
         ST_I_HEAD: begin
            if (pool_size_ff[k_ff]) begin
               attr_we    = 1'b1;
               attr_waddr = cur_ff[PAGE_W-1:0];
               attr_wdata = '{order: k_ff, alloc: 1'b0};
               link_wr    = '{next_en: 1'b1, prev_en: 1'b1,
                              addr: cur_ff[PAGE_W-1:0],
                              data: '{next: NIL, prev: NIL}};
               head_we    = 1'b1;
               head_widx  = k_ff;
               head_wdata = cur_ff;
               cur_in     = cur_ff + pow_k;
            end
            if (k_ff == '0) begin
               state_in = ST_RESP;
            end else begin
               k_in = k_ff - 1'b1;
            end
         end

         ST_RESP: begin
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pool_pages_ff <= COUNT_W'(MAX_PAGES);
         pool_size_ff  <= '0;
         free_total_ff <= '0;
      end else begin
         state_ff      <= state_in;
         pool_size_ff  <= pool_size_in;
         free_total_ff <= free_total_in;
         if (csr_valid && csr_ready) begin
            pool_pages_ff <= csr_pool_pages;
         end
      end
   end

   // Free-list heads.
   always_ff @(posedge clock) begin
      if (reset || head_clr) begin
         for (int j = 0; j < MAX_ORDER; j++) begin
            head_ff[j] <= NIL;
         end
      end else if (head_we) begin
         head_ff[head_widx] <= head_wdata;
      end
   end

   // Working and response payload registers.
   always_ff @(posedge clock) begin
      p_ff      <= p_in;
      b_ff      <= b_in;
      k_ff      <= k_in;
      req_ff    <= req_in;
      idx_ff    <= idx_in;
      cur_ff    <= cur_in;
      nx_ff     <= nx_in;
      pr_ff     <= pr_in;
      status_ff <= status_in;
      bpage_ff  <= bpage_in;
      border_ff <= border_in;
   end

   // Page attribute memory.
   always_ff @(posedge clock) begin
      if (attr_we) begin
         attr_mem[attr_waddr] <= attr_wdata;
      end
      attr_q <= attr_mem[attr_raddr];
   end

   // Free-list link memory, each half written on its own enable.
   always_ff @(posedge clock) begin
      if (link_wr.next_en) begin
         link_mem[link_wr.addr].next <= link_wr.data.next;
      end
      if (link_wr.prev_en) begin
         link_mem[link_wr.addr].prev <= link_wr.data.prev;
      end
      link_q <= link_mem[link_raddr];
   end

   // The response strobe lasts a single cycle.
   a_rsp_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   // A taken request always makes the block busy next cycle.
   a_take_busy : assert property (@(posedge clock) disable iff (reset)
      take |=> busy)
      else $error("request taken but block not busy");

   // The free page total never exceeds the pool.
   a_free_bound : assert property (@(posedge clock) disable iff (reset)
      free_total_ff <= pool_size_ff)
      else $error("free page total exceeds pool size");

   // Merging never climbs past the largest order.
   a_merge_order : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_F_UNL1) |-> (k_ff < ORDER_W'(MAX_ORDER - 1)))
      else $error("merge beyond largest order");

endmodule : buddy_page_allocator

`default_nettype wire
